>>> design/qpm_pkg.sv
// ----------------------------------------------------------------------------
// qpm_pkg: shared types and constants for the quadrotor PD motor mixer
// Item structs, sequencer opcodes, controller states and the CORDIC table.
// ----------------------------------------------------------------------------
`default_nettype none

package qpm_pkg;

  localparam int CORDIC_STEPS_DEF = 14;
  localparam int ATAN_LEN         = 24;
  localparam int STEP_W           = 6;

  typedef enum logic [2:0] {
    REG_P_GAIN     = 3'd0,
    REG_I_GAIN     = 3'd1,
    REG_D_GAIN     = 3'd2,
    REG_CLIMB_GAIN = 3'd3,
    REG_HOVER      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;
    logic signed [15:0] vertical_speed;
    logic               clear_state;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] motor_a;
    logic signed [31:0] motor_b;
    logic signed [31:0] motor_c;
    logic signed [31:0] motor_d;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  reg_index;
    logic [15:0] wdata;
  } cfg_wr_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_XZ, OP_WY, OP_YZ, OP_WX, OP_XX, OP_YY, OP_ZZ, OP_XY, OP_WZ,
    OP_EX, OP_EY, OP_EZ, OP_EFIN, OP_V, OP_P, OP_I, OP_D, OP_TFIN,
    OP_RY, OP_RA, OP_PX, OP_PB, OP_WAITC, OP_YFIN, OP_RPFIN, OP_S, OP_FAC,
    OP_M0, OP_M1, OP_M2, OP_M3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic cordic_start;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
  } sts_t;

  localparam logic [STEP_W-1:0] SEQ_LAST     = 6'd32;
  localparam logic [STEP_W-1:0] CORDIC_START = 6'd10;

  // Microcode: one op per step; a product lands in the cycle after its op.
  function automatic op_e seq_op(input logic [STEP_W-1:0] step);
    op_e r;
    case (step)
      6'd0:  r = OP_XZ;
      6'd1:  r = OP_WY;
      6'd2:  r = OP_YZ;
      6'd3:  r = OP_WX;
      6'd4:  r = OP_XX;
      6'd5:  r = OP_YY;
      6'd6:  r = OP_ZZ;
      6'd7:  r = OP_XY;
      6'd8:  r = OP_WZ;
      6'd9:  r = OP_EX;
      6'd10: r = OP_EY;
      6'd11: r = OP_EZ;
      6'd12: r = OP_EFIN;
      6'd13: r = OP_V;
      6'd14: r = OP_P;
      6'd15: r = OP_I;
      6'd16: r = OP_D;
      6'd17: r = OP_TFIN;
      6'd18: r = OP_RY;
      6'd19: r = OP_RA;
      6'd20: r = OP_PX;
      6'd21: r = OP_PB;
      6'd22: r = OP_WAITC;
      6'd23: r = OP_YFIN;
      6'd24: r = OP_RPFIN;
      6'd25: r = OP_S;
      6'd26: r = OP_FAC;
      6'd28: r = OP_M0;
      6'd29: r = OP_M1;
      6'd30: r = OP_M2;
      6'd31: r = OP_M3;
      default: r = OP_NOP;
    endcase
    return r;
  endfunction

  // atan(2^-i) at scale 2^30
  function automatic logic signed [33:0] atan_val(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  localparam logic signed [33:0] PI_Z     = 34'sd3373259426;
  localparam logic signed [31:0] K_SMALL  = 32'sd328;
  localparam logic signed [31:0] K_TILT_D = 32'sd137626;
  localparam logic signed [31:0] K_SPIN   = 32'sd13108;

endpackage

`default_nettype wire

>>> design/qpm_stream_if.sv
// ----------------------------------------------------------------------------
// qpm_stream_if: valid/ready channel
// Carries one payload of type T per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface qpm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/qpm_cordic.sv
// ----------------------------------------------------------------------------
// qpm_cordic: iterative vectoring CORDIC for atan2
// One rotation per cycle; result rounded to Q2.13.
// ----------------------------------------------------------------------------
`default_nettype none

module qpm_cordic import qpm_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [34:0] x_i,
  input  wire logic signed [34:0] y_i,
  output logic                    done_o,
  output logic signed [15:0]      yaw_o
);

  localparam int CW = $clog2(CORDIC_STEPS);

  logic signed [37:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [33:0] z_q, z_d, z_rnd;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    xs     = x_q >>> cnt_q;
    ys     = y_q >>> cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      if (x_i < 0) begin
        // pre-rotate by pi into the right half plane
        x_d = -38'(x_i);
        y_d = -38'(y_i);
        z_d = (y_i >= 0) ? PI_Z : -PI_Z;
      end else begin
        x_d = 38'(x_i);
        y_d = 38'(y_i);
        z_d = '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_val(5'(cnt_q));
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_val(5'(cnt_q));
      end
      if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign z_rnd  = (z_q + 34'sd65536) >>> 17;
  assign yaw_o  = (z_rnd > 34'sd32767) ? 16'sh7FFF :
                  (z_rnd < -34'sd32768) ? 16'sh8000 : z_rnd[15:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> design/qpm_datapath.sv
// ----------------------------------------------------------------------------
// qpm_datapath: shared multiplier, accumulators and kept controller state
// Executes one microcode op per cycle; products retire in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qpm_datapath import qpm_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cmd_t      cmd_i,
  output sts_t           sts_o,
  input  wire in_item_t  item_i,
  output out_item_t      item_o,
  input  wire logic      cfg_we_i,
  input  wire cfg_wr_t   cfg_i
);

  localparam logic signed [34:0] ONE28 = 35'sd268435456;
  localparam logic signed [33:0] ONE16 = 34'sd65536;

  // configuration
  logic signed [15:0] p_gain_q, i_gain_q, d_gain_q, climb_gain_q;
  logic [15:0]        hover_q;

  // kept state
  logic signed [39:0] sum_q;
  logic signed [23:0] last_e_q;
  logic signed [15:0] prev_a_q, prev_b_q, prev_ty_q, prev_tx_q, prev_yaw_q;

  // working registers
  in_item_t           it_q;
  op_e                op_q;
  logic signed [71:0] prod_q;
  logic signed [34:0] a20_q, a21_q, a22_q, a00_q, a10_q;
  logic signed [51:0] eacc_q;
  logic signed [23:0] e_q;
  logic signed [24:0] de_q;
  logic signed [59:0] tacc_q;
  logic signed [31:0] thrust_q;
  logic signed [15:0] tilt_a_q, tilt_b_q, yaw_q;
  logic signed [16:0] da_q, db_q, dy_q, dx_q, dyaw_q;
  logic signed [43:0] rc_q, pc_q;
  logic signed [33:0] rcf_q, pcf_q, scf_q;
  logic signed [33:0] fac_q [4];
  logic signed [31:0] motor_q [4];

  logic signed [39:0] mul_a;
  logic signed [31:0] mul_b;

  logic signed [51:0] e_rnd;
  logic signed [23:0] e_new;
  logic signed [40:0] sum_w;
  logic signed [39:0] sum_new;
  logic signed [59:0] t_rnd;
  logic signed [34:0] ta_rnd, tb_rnd;
  logic signed [15:0] ta_new, tb_new, cordic_yaw, yaw_new;
  logic signed [34:0] p2;
  logic signed [43:0] rc_rnd, pc_rnd;
  logic signed [35:0] sc_w, sc_rnd;
  logic signed [71:0] m_rnd;
  logic signed [31:0] m_sat;
  logic               lock;
  logic               cordic_done;

  // operand select for the op issued this cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_XZ: begin mul_a = 40'(it_q.quat_x); mul_b = 32'(it_q.quat_z); end
      OP_WY: begin mul_a = 40'(it_q.quat_w); mul_b = 32'(it_q.quat_y); end
      OP_YZ: begin mul_a = 40'(it_q.quat_y); mul_b = 32'(it_q.quat_z); end
      OP_WX: begin mul_a = 40'(it_q.quat_w); mul_b = 32'(it_q.quat_x); end
      OP_XX: begin mul_a = 40'(it_q.quat_x); mul_b = 32'(it_q.quat_x); end
      OP_YY: begin mul_a = 40'(it_q.quat_y); mul_b = 32'(it_q.quat_y); end
      OP_ZZ: begin mul_a = 40'(it_q.quat_z); mul_b = 32'(it_q.quat_z); end
      OP_XY: begin mul_a = 40'(it_q.quat_x); mul_b = 32'(it_q.quat_y); end
      OP_WZ: begin mul_a = 40'(it_q.quat_w); mul_b = 32'(it_q.quat_z); end
      OP_EX: begin mul_a = 40'(a20_q); mul_b = 32'(it_q.target_x); end
      OP_EY: begin mul_a = 40'(a21_q); mul_b = 32'(it_q.target_y); end
      OP_EZ: begin mul_a = 40'(a22_q); mul_b = 32'(it_q.target_z); end
      OP_V:  begin mul_a = 40'(it_q.vertical_speed); mul_b = 32'(climb_gain_q); end
      OP_P:  begin mul_a = 40'(e_q); mul_b = 32'(p_gain_q); end
      OP_I:  begin mul_a = sum_q; mul_b = 32'(i_gain_q); end
      OP_D:  begin mul_a = 40'(de_q); mul_b = 32'(d_gain_q); end
      OP_RY: begin mul_a = 40'(it_q.target_y); mul_b = K_SMALL; end
      OP_RA: begin mul_a = 40'(da_q); mul_b = K_TILT_D; end
      OP_PX: begin mul_a = 40'(it_q.target_x); mul_b = K_SMALL; end
      OP_PB: begin mul_a = 40'(db_q); mul_b = K_TILT_D; end
      OP_S:  begin mul_a = 40'(yaw_q); mul_b = K_SPIN; end
      OP_M0: begin mul_a = 40'(fac_q[0]); mul_b = thrust_q; end
      OP_M1: begin mul_a = 40'(fac_q[1]); mul_b = thrust_q; end
      OP_M2: begin mul_a = 40'(fac_q[2]); mul_b = thrust_q; end
      OP_M3: begin mul_a = 40'(fac_q[3]); mul_b = thrust_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // retire-side arithmetic
  assign p2      = {prod_q[33:0], 1'b0};
  assign e_rnd   = (eacc_q + 52'sd8388608) >>> 24;
  assign e_new   = (e_rnd > 52'sd8388607) ? 24'sh7FFFFF :
                   (e_rnd < -52'sd8388608) ? 24'sh800000 : e_rnd[23:0];
  assign sum_w   = 41'(sum_q) + 41'(e_new);
  assign sum_new = (sum_w[40] != sum_w[39]) ?
                   (sum_w[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}}) : sum_w[39:0];
  assign t_rnd   = (tacc_q + 60'sd8) >>> 4;
  assign ta_rnd  = (a21_q + 35'sd8192) >>> 14;
  assign tb_rnd  = (a20_q + 35'sd8192) >>> 14;
  assign ta_new  = (ta_rnd > 35'sd32767) ? 16'sh7FFF :
                   (ta_rnd < -35'sd32768) ? 16'sh8000 : ta_rnd[15:0];
  assign tb_new  = (tb_rnd > 35'sd32767) ? 16'sh7FFF :
                   (tb_rnd < -35'sd32768) ? 16'sh8000 : tb_rnd[15:0];
  assign lock    = (a20_q >= ONE28) || (a20_q <= -ONE28) ||
                   ((a00_q == 35'sd0) && (a10_q == 35'sd0));
  assign yaw_new = lock ? 16'sd0 : cordic_yaw;
  assign rc_rnd  = (rc_q + 44'sd8192) >>> 14;
  assign pc_rnd  = (pc_q + 44'sd8192) >>> 14;
  assign sc_w    = prod_q[35:0] + (36'(dyaw_q) <<< 18);
  assign sc_rnd  = (sc_w + 36'sd8192) >>> 14;
  assign m_rnd   = (prod_q + 72'sd32768) >>> 16;
  assign m_sat   = (m_rnd > 72'sd2147483647) ? 32'sh7FFFFFFF :
                   (m_rnd < -72'sd2147483648) ? 32'sh80000000 : m_rnd[31:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_gain_q     <= 16'sd512;
      i_gain_q     <= 16'sd0;
      d_gain_q     <= 16'sd0;
      climb_gain_q <= -16'sd512;
      hover_q      <= 16'd1366;
    end else if (cfg_we_i) begin
      case (cfg_i.reg_index)
        REG_P_GAIN:     p_gain_q     <= cfg_i.wdata;
        REG_I_GAIN:     i_gain_q     <= cfg_i.wdata;
        REG_D_GAIN:     d_gain_q     <= cfg_i.wdata;
        REG_CLIMB_GAIN: climb_gain_q <= cfg_i.wdata;
        REG_HOVER:      hover_q      <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // kept state and retire op
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= OP_NOP;
      sum_q      <= '0;
      last_e_q   <= '0;
      prev_a_q   <= '0;
      prev_b_q   <= '0;
      prev_ty_q  <= '0;
      prev_tx_q  <= '0;
      prev_yaw_q <= '0;
    end else begin
      op_q <= cmd_i.op;
      if (cmd_i.load && item_i.clear_state) begin
        sum_q      <= '0;
        last_e_q   <= '0;
        prev_a_q   <= '0;
        prev_b_q   <= '0;
        prev_ty_q  <= '0;
        prev_tx_q  <= '0;
        prev_yaw_q <= '0;
      end
      case (op_q)
        OP_EFIN: begin
          sum_q    <= sum_new;
          last_e_q <= e_new;
        end
        OP_TFIN: begin
          prev_a_q  <= ta_new;
          prev_b_q  <= tb_new;
          prev_ty_q <= it_q.target_y;
          prev_tx_q <= it_q.target_x;
        end
        OP_YFIN: prev_yaw_q <= yaw_new;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q <= item_i;
    end
    prod_q <= mul_a * mul_b;
    case (op_q)
      OP_XZ: a20_q <= p2;
      OP_WY: a20_q <= a20_q - p2;
      OP_YZ: a21_q <= p2;
      OP_WX: a21_q <= a21_q + p2;
      OP_XX: a22_q <= ONE28 - p2;
      OP_YY: begin
        a22_q <= a22_q - p2;
        a00_q <= ONE28 - p2;
      end
      OP_ZZ: a00_q <= a00_q - p2;
      OP_XY: a10_q <= p2;
      OP_WZ: a10_q <= a10_q + p2;
      OP_EX: eacc_q <= prod_q[51:0];
      OP_EY: eacc_q <= eacc_q + prod_q[51:0];
      OP_EZ: eacc_q <= eacc_q + prod_q[51:0];
      OP_EFIN: begin
        e_q  <= e_new;
        de_q <= 25'(e_new) - 25'(last_e_q);
      end
      OP_V: tacc_q <= (prod_q[59:0] <<< 4) + (60'(hover_q) <<< 12);
      OP_P, OP_I, OP_D: tacc_q <= tacc_q + prod_q[59:0];
      OP_TFIN: begin
        thrust_q <= (t_rnd > 60'sd2147483647) ? 32'sh7FFFFFFF :
                    (t_rnd < -60'sd2147483648) ? 32'sh80000000 : t_rnd[31:0];
        tilt_a_q <= ta_new;
        tilt_b_q <= tb_new;
        da_q     <= 17'(ta_new) - 17'(prev_a_q);
        db_q     <= 17'(tb_new) - 17'(prev_b_q);
        dy_q     <= 17'(it_q.target_y) - 17'(prev_ty_q);
        dx_q     <= 17'(it_q.target_x) - 17'(prev_tx_q);
      end
      OP_RY: rc_q <= (44'(tilt_a_q) <<< 14) + (prod_q[43:0] <<< 6) + (44'(dy_q) <<< 22);
      OP_RA: rc_q <= rc_q + prod_q[43:0];
      OP_PX: pc_q <= -(44'(tilt_b_q) <<< 14) - (prod_q[43:0] <<< 6) - (44'(dx_q) <<< 22);
      OP_PB: pc_q <= pc_q - prod_q[43:0];
      OP_YFIN: begin
        yaw_q  <= yaw_new;
        dyaw_q <= 17'(yaw_new) - 17'(prev_yaw_q);
      end
      OP_RPFIN: begin
        rcf_q <= rc_rnd[33:0];
        pcf_q <= pc_rnd[33:0];
      end
      OP_S: scf_q <= sc_rnd[33:0];
      OP_FAC: begin
        fac_q[0] <= ONE16 - rcf_q + pcf_q + scf_q;
        fac_q[1] <= ONE16 - rcf_q - pcf_q - scf_q;
        fac_q[2] <= ONE16 + rcf_q - pcf_q + scf_q;
        fac_q[3] <= ONE16 + rcf_q + pcf_q - scf_q;
      end
      OP_M0: motor_q[0] <= m_sat;
      OP_M1: motor_q[1] <= m_sat;
      OP_M2: motor_q[2] <= m_sat;
      OP_M3: motor_q[3] <= m_sat;
      default: ;
    endcase
  end

  qpm_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .x_i     (a00_q),
    .y_i     (a10_q),
    .done_o  (cordic_done),
    .yaw_o   (cordic_yaw)
  );

  assign sts_o.cordic_done = cordic_done;
  assign item_o.motor_a    = motor_q[0];
  assign item_o.motor_b    = motor_q[1];
  assign item_o.motor_c    = motor_q[2];
  assign item_o.motor_d    = motor_q[3];

endmodule

`default_nettype wire

>>> design/qpm_ctrl.sv
// ----------------------------------------------------------------------------
// qpm_ctrl: sequencer for the motor mixer
// Steps through the microcode, waits on the CORDIC, holds the result valid until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module qpm_ctrl import qpm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire sts_t  sts_i,
  output cmd_t       cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '{load: 1'b0, cordic_start: 1'b0, op: OP_NOP};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.op           = seq_op(step_q);
        cmd_o.cordic_start = (step_q == CORDIC_START);
        if (step_q == SEQ_LAST) begin
          state_d = ST_OUT;
        end else if (!(cmd_o.op == OP_WAITC && !sts_i.cordic_done)) begin
          step_d = step_q + 1'b1;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_load_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_RUN && step_q == '0))
    else $error("load did not start the sequence");

  a_wait_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cmd_o.op == OP_WAITC && !sts_i.cordic_done)
      |=> (step_q == $past(step_q)))
    else $error("sequence advanced before atan2 finished");

endmodule

`default_nettype wire

>>> design/quadrotor_pd_motor_mixer_core.sv
// ----------------------------------------------------------------------------
// quadrotor_pd_motor_mixer_core: attitude/height PD mixer, four motor outputs
// Each item runs through the 33-step shared-multiplier sequence from input accept
// to result valid, waiting at step 22 while the atan2 unit is still running.
// Throughput: one item at a time; a new item is accepted only after the result
// has been taken by the receiver.
// Reset: gains return to their defaults and all kept errors clear to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrotor_pd_motor_mixer_core import qpm_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qpm_stream_if.sink   in_i,
  qpm_stream_if.source out_o,
  qpm_stream_if.sink   cfg_i
);

  cmd_t      cmd;
  sts_t      sts;
  out_item_t res;
  in_item_t  in_item;
  cfg_wr_t   cfg_wr;
  logic      in_ready, out_valid;

  assign in_item = in_i.data;
  assign cfg_wr  = cfg_i.data;

  qpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qpm_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .item_i   (in_item),
    .item_o   (res),
    .cfg_we_i (cfg_i.valid),
    .cfg_i    (cfg_wr)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = res;
  assign cfg_i.ready = 1'b1;

endmodule

`default_nettype wire
